### hw/rtl/acrw_pkg.sv
// Shared types, widths and codes of the audio capture ring window block.
package acrw_pkg;

	// Sample store geometry.
	localparam int DEPTH  = 65536;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int LEN_W  = ADDR_W + 1;

	// Field widths.
	localparam int SAMPLE_W  = 32;
	localparam int WLEN_W    = 18;
	localparam int WIDX_W    = 17;
	localparam int STAT_W    = 2;
	localparam int RING_W    = 17;
	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 1;

	// Unreduced slot sum: position plus length minus window plus index.
	localparam int SUM_W = $clog2(2 * DEPTH + 2 ** WIDX_W);
	localparam int CNT_W = $clog2(SUM_W);

	// Command queue between front and back.
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_RECORDING   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_RING_LENGTH = CFG_IDX_W'(1);

	localparam logic [RING_W-1:0] RING_RESET = RING_W'(65536);

	// Commands.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// Read status codes.
	localparam logic [STAT_W-1:0] ST_SERVED = STAT_W'(0);
	localparam logic [STAT_W-1:0] ST_PAUSED = STAT_W'(1);
	localparam logic [STAT_W-1:0] ST_LONG   = STAT_W'(2);

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_READ,
		OP_PAUSED,
		OP_LONG
	} op_t;

	typedef struct packed {
		logic                command;
		logic [SAMPLE_W-1:0] sample;
		logic [WLEN_W-1:0]   window_length;
		logic [WIDX_W-1:0]   window_index;
	} in_item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] read_sample;
		logic [STAT_W-1:0]   read_status;
	} out_item_t;

	typedef struct packed {
		op_t                 op;
		logic [SUM_W-1:0]    addr;
		logic [SAMPLE_W-1:0] sample;
		logic [LEN_W-1:0]    len;
	} q_entry_t;

endpackage

### hw/rtl/audio_capture_ring_window.sv
// Top level of the audio capture ring window: front, command queue and back.
//
//   channel   direction  handshake              word
//   command   in         start / busy           item (in_item_t)
//   result    out        done, one-cycle strobe result (out_item_t)
//   config    in         cfg_write, no wait     cfg_index, cfg_data
//
// After reset the back end clears all 65536 store slots, one per cycle, and
// busy stays high until that is done; configuration writes are taken meanwhile.
// A write word is stored as the back end pops it; a paused or too-long read
// shows its result in the cycle after it is popped. For a served read the
// slot sum is reduced modulo the ring length by a one-bit-per-cycle restoring
// remainder unit, then the single-port store is read into a register. The
// front accepts a word every cycle while the four-entry queue has room; busy
// rises when it is full. The receiver cannot stall: each result is valid for
// exactly the done cycle.
module audio_capture_ring_window (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  acrw_pkg::in_item_t             item,
	output logic                           done,
	output acrw_pkg::out_item_t            result,
	input  logic                           cfg_write,
	input  logic [acrw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [acrw_pkg::CFG_W-1:0]     cfg_data
);

	logic               push;
	logic               pop;
	logic               q_full;
	logic               q_empty;
	logic               clearing;
	acrw_pkg::q_entry_t push_entry;
	acrw_pkg::q_entry_t head_entry;

	// No word is taken while the store is being cleared or the queue is full.
	assign busy = clearing || q_full;

	acrw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.entry     (push_entry)
	);

	// Words travel in order, so a read always sees every earlier write.
	acrw_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_entry),
		.pop    (pop),
		.rdata  (head_entry),
		.full   (q_full),
		.empty  (q_empty)
	);

	acrw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.entry    (head_entry),
		.pop      (pop),
		.clearing (clearing),
		.done     (done),
		.result   (result)
	);

endmodule

### hw/rtl/acrw_fifo.sv
// Short in-order command queue between the front and the back.
module acrw_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  acrw_pkg::q_entry_t wdata,
	input  logic              pop,
	output acrw_pkg::q_entry_t rdata,
	output logic              full,
	output logic              empty
);

	acrw_pkg::q_entry_t              entries_q [acrw_pkg::Q_DEPTH];
	logic [acrw_pkg::Q_PTR_W-1:0]    wr_ptr_q;
	logic [acrw_pkg::Q_PTR_W-1:0]    rd_ptr_q;
	logic [acrw_pkg::Q_PTR_W:0]      count_q;

	assign full  = (count_q == (acrw_pkg::Q_PTR_W + 1)'(acrw_pkg::Q_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue pushed while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("queue popped while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (acrw_pkg::Q_PTR_W + 1)'(acrw_pkg::Q_DEPTH))
		else $error("queue count beyond depth");

endmodule

### hw/rtl/acrw_front.sv
// Front end: configuration registers, write position and command classification.
module acrw_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  acrw_pkg::in_item_t            item,
	input  logic                          cfg_write,
	input  logic [acrw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [acrw_pkg::CFG_W-1:0]    cfg_data,
	output logic                          push,
	output acrw_pkg::q_entry_t            entry
);

	logic                          recording_q;
	logic [acrw_pkg::RING_W-1:0]   ring_length_q;
	logic [acrw_pkg::ADDR_W-1:0]   wp_q;

	logic                          accept;
	logic [acrw_pkg::LEN_W-1:0]    len_eff;
	logic [acrw_pkg::ADDR_W-1:0]   pos_eff;
	logic [acrw_pkg::LEN_W-1:0]    pos_next;
	logic                          too_long;
	logic [acrw_pkg::SUM_W-1:0]    slot_sum;

	always_comb begin
		// A zero length acts as one slot; lengths past the store saturate.
		if (ring_length_q == '0) begin
			len_eff = acrw_pkg::LEN_W'(1);
		end else if (32'(ring_length_q) > 32'(acrw_pkg::DEPTH)) begin
			len_eff = acrw_pkg::LEN_W'(acrw_pkg::DEPTH);
		end else begin
			len_eff = acrw_pkg::LEN_W'(ring_length_q);
		end

		// A position left beyond a shortened ring restarts at slot zero.
		pos_eff  = (acrw_pkg::LEN_W'(wp_q) >= len_eff) ? '0 : wp_q;
		pos_next = acrw_pkg::LEN_W'(pos_eff) + 1'b1;
		too_long = 32'(item.window_length) > 32'(len_eff);
		slot_sum = acrw_pkg::SUM_W'(pos_eff) + acrw_pkg::SUM_W'(len_eff)
			- acrw_pkg::SUM_W'(item.window_length) + acrw_pkg::SUM_W'(item.window_index);

		accept = start && !busy;

		entry.sample = item.sample;
		entry.len    = len_eff;
		if (item.command == acrw_pkg::CMD_WRITE) begin
			entry.op   = acrw_pkg::OP_WRITE;
			entry.addr = acrw_pkg::SUM_W'(pos_eff);
		end else if (!recording_q) begin
			entry.op   = acrw_pkg::OP_PAUSED;
			entry.addr = slot_sum;
		end else if (too_long) begin
			entry.op   = acrw_pkg::OP_LONG;
			entry.addr = slot_sum;
		end else begin
			entry.op   = acrw_pkg::OP_READ;
			entry.addr = slot_sum;
		end

		// Paused writes leave no trace at all.
		push = accept && !(item.command == acrw_pkg::CMD_WRITE && !recording_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recording_q   <= 1'b0;
			ring_length_q <= acrw_pkg::RING_RESET;
			wp_q          <= '0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					acrw_pkg::REG_RECORDING:   recording_q   <= cfg_data[0];
					acrw_pkg::REG_RING_LENGTH: ring_length_q <= cfg_data[acrw_pkg::RING_W-1:0];
					default: ;
				endcase
			end
			if (accept && item.command == acrw_pkg::CMD_WRITE && recording_q) begin
				wp_q <= (pos_next >= len_eff) ? '0 : pos_next[acrw_pkg::ADDR_W-1:0];
			end
		end
	end

endmodule

### hw/rtl/acrw_back.sv
// Back end: sample store, clearing pass, slot reduction and read-out.
module acrw_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  acrw_pkg::q_entry_t entry,
	output logic               pop,
	output logic               clearing,
	output logic               done,
	output acrw_pkg::out_item_t result
);

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_DIV,
		B_RD
	} bstate_t;

	bstate_t                              state_q;
	logic [acrw_pkg::ADDR_W-1:0]          clr_q;
	logic [acrw_pkg::SUM_W-1:0]           div_q;
	logic [acrw_pkg::ADDR_W-1:0]          rem_q;
	logic [acrw_pkg::LEN_W-1:0]           len_q;
	logic [acrw_pkg::CNT_W-1:0]           cnt_q;
	logic                                 done_q;
	logic [acrw_pkg::STAT_W-1:0]          status_q;

	logic [acrw_pkg::SAMPLE_W-1:0]        mem [acrw_pkg::DEPTH];
	logic [acrw_pkg::SAMPLE_W-1:0]        rd_data_q;

	logic                                 mem_we;
	logic [acrw_pkg::ADDR_W-1:0]          mem_wa;
	logic [acrw_pkg::SAMPLE_W-1:0]        mem_wd;
	logic [acrw_pkg::LEN_W-1:0]           trial;
	logic [acrw_pkg::ADDR_W-1:0]          rem_next;

	always_comb begin
		pop      = (state_q == B_IDLE) && !q_empty;
		clearing = (state_q == B_CLEAR);

		mem_we = clearing || (pop && entry.op == acrw_pkg::OP_WRITE);
		mem_wa = clearing ? clr_q : entry.addr[acrw_pkg::ADDR_W-1:0];
		mem_wd = clearing ? '0 : entry.sample;

		// One restoring step of the remainder by the ring length.
		trial = {rem_q, div_q[acrw_pkg::SUM_W-1]};
		if (trial >= len_q) begin
			rem_next = acrw_pkg::ADDR_W'(trial - len_q);
		end else begin
			rem_next = trial[acrw_pkg::ADDR_W-1:0];
		end

		done               = done_q;
		result.read_status = status_q;
		result.read_sample = (status_q == acrw_pkg::ST_SERVED) ? rd_data_q : '0;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (state_q == B_RD) begin
			rd_data_q <= mem[rem_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_CLEAR;
			clr_q    <= '0;
			div_q    <= '0;
			rem_q    <= '0;
			len_q    <= '0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			status_q <= acrw_pkg::ST_SERVED;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == acrw_pkg::ADDR_W'(acrw_pkg::DEPTH - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (pop) begin
						unique case (entry.op)
							acrw_pkg::OP_WRITE: ;
							acrw_pkg::OP_PAUSED: begin
								done_q   <= 1'b1;
								status_q <= acrw_pkg::ST_PAUSED;
							end
							acrw_pkg::OP_LONG: begin
								done_q   <= 1'b1;
								status_q <= acrw_pkg::ST_LONG;
							end
							acrw_pkg::OP_READ: begin
								div_q   <= entry.addr;
								rem_q   <= '0;
								len_q   <= entry.len;
								cnt_q   <= acrw_pkg::CNT_W'(acrw_pkg::SUM_W - 1);
								state_q <= B_DIV;
							end
							default: ;
						endcase
					end
				end
				B_DIV: begin
					rem_q <= rem_next;
					div_q <= div_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= B_RD;
					end
				end
				B_RD: begin
					done_q   <= 1'b1;
					status_q <= acrw_pkg::ST_SERVED;
					state_q  <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	a_rem_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DIV) |-> (acrw_pkg::LEN_W'(rem_q) < len_q))
		else $error("partial remainder not below ring length");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q == B_RD) ||
			($past(pop) && $past(entry.op) != acrw_pkg::OP_WRITE)))
		else $error("result strobe without a read behind it");

	a_no_write_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_RD) |-> !mem_we)
		else $error("store written during a read-out");

	a_clear_blocks_pop: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (!pop && !done_q))
		else $error("queue served during the clearing pass");

endmodule
